/* rtl/core/bbpa_pkg.sv */
// Shared types, constants and bitmap layout helpers for the buddy bitmap page allocator.
`timescale 1ns / 1ps
package bbpa_pkg;

  localparam int unsigned DEF_MAX_PAGES    = 65536;
  localparam int unsigned DEF_ORDER_LEVELS = 10;

  localparam logic [16:0] TOTAL_PAGES_RESET = 17'd65536;
  localparam logic [15:0] CONTIG_START_RESET = 16'd256;

  typedef enum logic [1:0] {
    CMD_REQUEST   = 2'd0,
    CMD_MARK_USED = 2'd1,
    CMD_MARK_FREE = 2'd2
  } cmd_t;

  typedef enum logic {
    REG_TOTAL_PAGES  = 1'b0,
    REG_CONTIG_START = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [16:0] page_count;
    logic        contiguous;
    logic [15:0] page_number;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [15:0] granted_page;
    logic [16:0] granted_count;
    logic [16:0] available_pages;
  } out_item_t;

  // 64-bit words holding one order's bitmap
  function automatic int unsigned words_at(int unsigned max_pages, int unsigned o);
    words_at = ((max_pages >> o) + 63) >> 6;
  endfunction

  // first word of an order's bitmap in the shared memory
  function automatic int unsigned word_base(int unsigned max_pages, int unsigned o);
    int unsigned acc;
    acc = 0;
    for (int unsigned k = 0; k < o; k++) begin
      acc = acc + words_at(max_pages, k);
    end
    word_base = acc;
  endfunction

endpackage

/* rtl/core/buddy_bitmap_page_allocator_core.sv */
// Top level of the buddy bitmap page allocator: sequencer, bitmap memory and APB registers.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_ready/in_data carries one command beat: request pages
//   (buddy block or first-fit contiguous run), mark pages used, or mark pages free.
//   Output channel out_valid/out_ready/out_data returns exactly one result beat per
//   command: grant flag, first page, page count and free pages left.
//   APB port sets total_pages (0x0) and contiguous_start_page (0x4); write only while idle.
// Operation:
//   All bitmaps of all orders share one single-port-write memory of 64-bit words, and
//   every bitmap bit is visited through a read state and then an evaluate state. An item
//   is decoded, then pages are scanned in a contiguous search or blocks checked in a buddy
//   search, the pages granted or named are marked, and each higher order is rebuilt block
//   by block from its pair of child bits before the result is posted.
//   One item is processed at a time; in_ready is high only between items.
// Reset:
//   rst clears the registers to their defaults and starts a clearing pass that zeroes the
//   bitmap memory, one word per cycle (DEPTH words, 2046 at the default size); no command
//   is taken until it ends.
// Stall:
//   A finished result waits in the output register; a new command is accepted meanwhile,
//   and the next result is held in the sequencer until the output register frees up.
module buddy_bitmap_page_allocator_core #(
  parameter int unsigned MAX_PAGES    = bbpa_pkg::DEF_MAX_PAGES,
  parameter int unsigned ORDER_LEVELS = bbpa_pkg::DEF_ORDER_LEVELS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bbpa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bbpa_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import bbpa_pkg::*;

  localparam int unsigned LG    = $clog2(MAX_PAGES);
  localparam int unsigned CW    = (LG + 1 > 17) ? LG + 1 : 17;
  localparam int unsigned IW    = CW + 1;
  localparam int unsigned OW    = $clog2(ORDER_LEVELS + 1);
  localparam int unsigned OIW   = $clog2(ORDER_LEVELS);
  localparam int unsigned DEPTH = word_base(MAX_PAGES, ORDER_LEVELS);
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [CW-1:0] MAXC = CW'(MAX_PAGES);
  localparam logic [CW-1:0] BMAX = CW'(1) << (ORDER_LEVELS - 1);

  typedef enum logic [14:0] {
    ST_CLEAR  = 15'h0001,
    ST_IDLE   = 15'h0002,
    ST_DECODE = 15'h0004,
    ST_CRD    = 15'h0008,
    ST_CEV    = 15'h0010,
    ST_BCHK   = 15'h0020,
    ST_BRD    = 15'h0040,
    ST_BEV    = 15'h0080,
    ST_M0RD   = 15'h0100,
    ST_M0EV   = 15'h0200,
    ST_MCHK   = 15'h0400,
    ST_MCRD   = 15'h0800,
    ST_MCEV   = 15'h1000,
    ST_MPRD   = 15'h2000,
    ST_MPEV   = 15'h4000
  } state_t;

  state_t state;
  logic   fin;

  in_item_t      item;
  logic [16:0]   total_pages;
  logic [15:0]   contig_start;
  logic [CW-1:0] used;
  logic [IW-1:0] p, st, b, mfirst, mlast;
  logic [CW-1:0] run, gpage, gcount;
  logic [OW-1:0] o;
  logic          mused, cv, ok;
  logic [AW-1:0] addr, clr;
  logic [5:0]    bp;
  logic          oor;

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata, wword;
  logic        we;
  logic [AW-1:0] waddr;
  logic [63:0] wdata;

  logic [AW-1:0] base_tbl [ORDER_LEVELS];
  for (genvar k = 0; k < ORDER_LEVELS; k++) begin : g_base
    assign base_tbl[k] = AW'(word_base(MAX_PAGES, k));
  end

  // effective size and free count
  logic [CW-1:0] eff, avail, cnt;
  assign eff   = (CW'(total_pages) > MAXC) ? MAXC : CW'(total_pages);
  assign avail = (eff > used) ? eff - used : '0;
  assign cnt   = CW'(item.page_count);

  // buddy order choice
  logic [OW-1:0] lvl_raw, lvl;
  logic [CW-1:0] rem;
  always_comb begin
    lvl_raw = '0;
    for (int k = 0; k < ORDER_LEVELS - 1; k++) begin
      if (cnt > (CW'(1) << k)) lvl_raw = OW'(k + 1);
    end
    lvl = lvl_raw;
    rem = '0;
    if (cnt != (CW'(1) << lvl_raw) && lvl_raw >= OW'(2)) begin
      rem = cnt - (CW'(1) << (lvl_raw - OW'(1)));
      if (rem < (CW'(1) << (lvl_raw - OW'(2)))) lvl = lvl_raw - OW'(1);
    end
  end

  // bitmap bit addressed by the current read state
  logic [OW-1:0] acc_o;
  logic [IW-1:0] acc_idx;
  logic [AW-1:0] addr_c;
  logic          oor_c;
  always_comb begin
    acc_o   = '0;
    acc_idx = '0;
    case (state)
      ST_CRD, ST_M0RD: begin
        acc_o   = '0;
        acc_idx = p;
      end
      ST_BRD, ST_MPRD: begin
        acc_o   = o;
        acc_idx = b;
      end
      ST_MCRD: begin
        acc_o   = o - OW'(1);
        acc_idx = b << 1;
      end
      default: begin
        acc_o   = '0;
        acc_idx = '0;
      end
    endcase
  end
  assign addr_c = base_tbl[acc_o[OIW-1:0]] + AW'(acc_idx >> 6);
  assign oor_c  = acc_idx >= (IW'(MAX_PAGES) >> acc_o);

  logic bitv, pairv;
  assign bitv  = rdata[bp] & ~oor;
  assign pairv = (rdata[{bp[5:1], 1'b0}] | rdata[{bp[5:1], 1'b1}]) & ~oor;

  always_comb begin
    wword = rdata;
    wword[bp] = (state == ST_M0EV) ? mused : cv;
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = wword;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
        wdata = '0;
      end
      ST_M0EV, ST_MPEV: we = ~oor;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[addr_c];
  end

  // APB registers
  reg_index_t ridx;
  assign ridx   = reg_index_t'(paddr[2]);
  assign pready = 1'b1;
  always_comb begin
    case (ridx)
      REG_TOTAL_PAGES:  prdata = 32'(total_pages);
      REG_CONTIG_START: prdata = 32'(contig_start);
      default:          prdata = '0;
    endcase
  end

  assign in_ready = (state == ST_IDLE) && !fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages  <= TOTAL_PAGES_RESET;
      contig_start <= CONTIG_START_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (ridx)
        REG_TOTAL_PAGES:  total_pages  <= pwdata[16:0];
        REG_CONTIG_START: contig_start <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (fin && (!out_valid || out_ready)) begin
        out_valid                <= 1'b1;
        out_data.granted         <= ok;
        out_data.granted_page    <= ok ? gpage[15:0] : '0;
        out_data.granted_count   <= ok ? gcount[16:0] : '0;
        out_data.available_pages <= avail[16:0];
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
      used  <= '0;
      fin   <= 1'b0;
    end else begin
      if (fin && (!out_valid || out_ready)) fin <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            item  <= in_data;
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          case (cmd_t'(item.command))
            CMD_REQUEST: begin
              ok     <= 1'b0;
              gpage  <= '0;
              gcount <= '0;
              if (cnt != '0 && cnt <= avail && item.contiguous &&
                  CW'(contig_start) < eff) begin
                p     <= IW'(contig_start);
                st    <= IW'(contig_start);
                run   <= '0;
                state <= ST_CRD;
              end else if (cnt != '0 && cnt <= avail && !item.contiguous &&
                           cnt <= BMAX) begin
                o     <= lvl;
                b     <= '0;
                state <= ST_BCHK;
              end else begin
                state <= ST_IDLE;
                fin   <= 1'b1;
              end
            end
            CMD_MARK_USED, CMD_MARK_FREE: begin
              if (cnt != '0 && CW'(item.page_number) < eff) begin
                ok     <= 1'b1;
                gpage  <= CW'(item.page_number);
                gcount <= (cnt < eff - CW'(item.page_number)) ? cnt
                                                               : eff - CW'(item.page_number);
                mfirst <= IW'(item.page_number);
                mlast  <= IW'(item.page_number) - IW'(1) +
                          IW'((cnt < eff - CW'(item.page_number)) ? cnt
                                                                   : eff - CW'(item.page_number));
                mused  <= (cmd_t'(item.command) == CMD_MARK_USED);
                p      <= IW'(item.page_number);
                state  <= ST_M0RD;
              end else begin
                ok     <= 1'b0;
                gpage  <= '0;
                gcount <= '0;
                state  <= ST_IDLE;
                fin    <= 1'b1;
              end
            end
            default: begin
              ok     <= 1'b0;
              gpage  <= '0;
              gcount <= '0;
              state  <= ST_IDLE;
              fin    <= 1'b1;
            end
          endcase
        end
        ST_CRD, ST_BRD, ST_M0RD, ST_MCRD, ST_MPRD: begin
          addr <= addr_c;
          bp   <= acc_idx[5:0];
          oor  <= oor_c;
          case (state)
            ST_CRD:  state <= ST_CEV;
            ST_BRD:  state <= ST_BEV;
            ST_M0RD: state <= ST_M0EV;
            ST_MCRD: state <= ST_MCEV;
            default: state <= ST_MPEV;
          endcase
        end
        ST_CEV: begin
          if (!bitv && run + CW'(1) == cnt) begin
            ok     <= 1'b1;
            gpage  <= CW'(st);
            gcount <= cnt;
            mfirst <= st;
            mlast  <= st + IW'(cnt) - IW'(1);
            mused  <= 1'b1;
            p      <= st;
            state  <= ST_M0RD;
          end else begin
            if (bitv) begin
              run <= '0;
              st  <= p + IW'(1);
            end else begin
              run <= run + CW'(1);
            end
            if (p + IW'(1) >= IW'(eff)) begin
              state <= ST_IDLE;
              fin   <= 1'b1;
            end else begin
              p     <= p + IW'(1);
              state <= ST_CRD;
            end
          end
        end
        ST_BCHK: begin
          if (b < (IW'(eff) >> o)) begin
            state <= ST_BRD;
          end else if (o == '0) begin
            state <= ST_IDLE;
            fin   <= 1'b1;
          end else begin
            o <= o - OW'(1);
            b <= '0;
          end
        end
        ST_BEV: begin
          if (!bitv) begin
            ok     <= 1'b1;
            gpage  <= CW'(b << o);
            gcount <= CW'(1) << o;
            mfirst <= b << o;
            mlast  <= (b << o) + (IW'(1) << o) - IW'(1);
            mused  <= 1'b1;
            p      <= b << o;
            state  <= ST_M0RD;
          end else begin
            b     <= b + IW'(1);
            state <= ST_BCHK;
          end
        end
        ST_M0EV: begin
          if (mused && !bitv) used <= used + CW'(1);
          else if (!mused && bitv && used != '0) used <= used - CW'(1);
          if (p == mlast) begin
            o     <= OW'(1);
            b     <= mfirst >> 1;
            state <= ST_MCHK;
          end else begin
            p     <= p + IW'(1);
            state <= ST_M0RD;
          end
        end
        ST_MCHK: begin
          if (o == OW'(ORDER_LEVELS)) begin
            state <= ST_IDLE;
            fin   <= 1'b1;
          end else if (b <= (mlast >> o)) begin
            state <= ST_MCRD;
          end else begin
            o <= o + OW'(1);
            b <= mfirst >> (o + OW'(1));
          end
        end
        ST_MCEV: begin
          cv    <= pairv;
          state <= ST_MPRD;
        end
        ST_MPEV: begin
          b     <= b + IW'(1);
          state <= ST_MCHK;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_used_bound: assert property (@(posedge clk) disable iff (rst) used <= MAXC)
    else $error("used page total beyond memory size");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");
  a_no_take_in_clear: assert property (@(posedge clk) state == ST_CLEAR |-> !in_ready)
    else $error("beat taken during clearing pass");
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.granted |-> out_data.granted_page == '0 &&
    out_data.granted_count == '0)
    else $error("refused result carries a page range");

endmodule

/* verif/buddy_bitmap_page_allocator_core_test.sv */
// Self-checking testbench for the buddy bitmap page allocator core.
`timescale 1ns / 1ps

class page_ledger;
  localparam int unsigned MAXP = bbpa_pkg::DEF_MAX_PAGES;
  localparam int unsigned ORD  = bbpa_pkg::DEF_ORDER_LEVELS;

  bit used_map [ORD][MAXP];
  int unsigned used_pages;
  int unsigned total_reg;
  int unsigned start_reg;
  bbpa_pkg::out_item_t due_q[$];
  int unsigned errors;

  function new();
    used_pages = 0;
    total_reg  = bbpa_pkg::TOTAL_PAGES_RESET;
    start_reg  = bbpa_pkg::CONTIG_START_RESET;
    errors     = 0;
  endfunction

  function void set_reg(bbpa_pkg::reg_index_t idx, int unsigned val);
    if (idx == bbpa_pkg::REG_TOTAL_PAGES) total_reg = val & 17'h1ffff;
    else start_reg = val & 16'hffff;
  endfunction

  function int unsigned managed();
    return (total_reg > MAXP) ? MAXP : total_reg;
  endfunction

  function int unsigned free_left();
    int unsigned t;
    t = managed();
    return (t > used_pages) ? t - used_pages : 0;
  endfunction

  function bit peek(int unsigned o, int unsigned idx);
    if (idx >= (MAXP >> o)) return 1'b0;
    return used_map[o][idx];
  endfunction

  function void poke(int unsigned o, int unsigned idx, bit v);
    if (idx < (MAXP >> o)) used_map[o][idx] = v;
  endfunction

  function void paint(int unsigned first, int unsigned n, bit mark_used);
    int unsigned last;
    last = first + n - 1;
    for (int unsigned p = first; p <= last; p++) begin
      if (mark_used && !peek(0, p)) used_pages++;
      else if (!mark_used && peek(0, p) && used_pages > 0) used_pages--;
      poke(0, p, mark_used);
    end
    for (int unsigned o = 1; o < ORD; o++)
      for (int unsigned b = first >> o; b <= (last >> o); b++)
        poke(o, b, peek(o - 1, 2 * b) | peek(o - 1, 2 * b + 1));
  endfunction

  function int lowest_free_block(int unsigned o);
    int unsigned n;
    n = managed() >> o;
    for (int unsigned b = 0; b < n; b++)
      if (!peek(o, b)) return b;
    return -1;
  endfunction

  function void note(bbpa_pkg::in_item_t it);
    bbpa_pkg::out_item_t e;
    int unsigned total, cnt, gpage, gcount, start, run, lvl, rem, n;
    int blk;
    bit ok;
    total = managed();
    cnt = it.page_count;
    ok = 0; gpage = 0; gcount = 0;
    if (it.command == bbpa_pkg::CMD_REQUEST) begin
      if (cnt != 0 && cnt <= free_left()) begin
        if (it.contiguous) begin
          start = start_reg; run = 0;
          for (int unsigned p = start_reg; p < total; p++) begin
            if (peek(0, p)) begin
              run = 0;
              start = p + 1;
            end else begin
              run++;
              if (run == cnt) begin
                ok = 1;
                break;
              end
            end
          end
          if (ok) begin
            gpage = start;
            gcount = cnt;
          end
        end else if (cnt <= (1 << (ORD - 1))) begin
          lvl = 0;
          while (lvl < ORD - 1 && cnt > (1 << lvl)) lvl++;
          // drop one order when more than a quarter would be wasted
          if (cnt != (1 << lvl) && lvl >= 2) begin
            rem = cnt - (1 << (lvl - 1));
            if (rem < (1 << (lvl - 2))) lvl--;
          end
          for (int o = lvl; o >= 0; o--) begin
            blk = lowest_free_block(o);
            if (blk >= 0) begin
              ok = 1;
              gpage = blk << o;
              gcount = 1 << o;
              break;
            end
          end
        end
        if (ok) paint(gpage, gcount, 1'b1);
      end
    end else if (it.command == bbpa_pkg::CMD_MARK_USED ||
                 it.command == bbpa_pkg::CMD_MARK_FREE) begin
      if (cnt != 0 && it.page_number < total) begin
        n = total - it.page_number;
        if (cnt < n) n = cnt;
        paint(it.page_number, n, it.command == bbpa_pkg::CMD_MARK_USED);
        ok = 1;
        gpage = it.page_number;
        gcount = n;
      end
    end
    e.granted         = ok;
    e.granted_page    = ok ? gpage[15:0] : 16'd0;
    e.granted_count   = ok ? gcount[16:0] : 17'd0;
    e.available_pages = 17'(free_left());
    due_q.push_back(e);
  endfunction

  function void check(bbpa_pkg::out_item_t got);
    bbpa_pkg::out_item_t e;
    if (due_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat %p", got);
      return;
    end
    e = due_q.pop_front();
    if (got.granted !== e.granted || got.granted_page !== e.granted_page ||
        got.granted_count !== e.granted_count ||
        got.available_pages !== e.available_pages) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected granted=%0d page=%0d count=%0d avail=%0d, got %0d %0d %0d %0d",
                 e.granted, e.granted_page, e.granted_count, e.available_pages,
                 got.granted, got.granted_page, got.granted_count, got.available_pages);
    end
  endfunction

  function int pending();
    return due_q.size();
  endfunction
endclass

module buddy_bitmap_page_allocator_core_test;
  import bbpa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 40_000_000;
  localparam int unsigned RANDOM_ITEMS = 1250;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  page_ledger ledger;
  int unsigned tx_idle, rx_idle, cycles, rand_count;

  buddy_bitmap_page_allocator_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("buddy_bitmap_page_allocator_core_test NOT OK");
      $finish;
    end
  end

  // result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) ledger.check(out_data);
    out_ready <= ($urandom_range(0, 99) >= rx_idle);
  end

  task automatic write_reg(reg_index_t idx, int unsigned val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 3'(int'(idx) * 4); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    ledger.set_reg(idx, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0);
  endtask

  task automatic set_memory(int unsigned total, int unsigned start);
    drain();
    repeat (20) @(posedge clk);
    write_reg(REG_TOTAL_PAGES, total);
    write_reg(REG_CONTIG_START, start);
  endtask

  task automatic send(cmd_t cmd, int unsigned cnt, bit contig, int unsigned page);
    in_item_t it;
    bit held;
    it.command = cmd; it.page_count = cnt; it.contiguous = contig; it.page_number = page;
    held = 0;
    while ($urandom_range(0, 99) < tx_idle) begin
      if (!held) in_valid <= 1'b0;
      held = 1;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    ledger.note(it);
  endtask

  task automatic random_phase(int unsigned total, int unsigned start, int unsigned items);
    int unsigned r, cnt, page;
    cmd_t cmd;
    set_memory(total, start);
    for (int unsigned k = 0; k < items; k++) begin
      if (rand_count < RANDOM_ITEMS / 3) begin
        tx_idle = 23; rx_idle = 73;
      end else if (rand_count < 2 * RANDOM_ITEMS / 3) begin
        tx_idle = 73; rx_idle = 23;
      end else begin
        tx_idle = 0; rx_idle = 0;
      end
      if (k == items / 3) drain();
      r = $urandom_range(0, 99);
      if (r < 45) cmd = CMD_REQUEST;
      else if (r < 70) cmd = CMD_MARK_USED;
      else if (r < 95) cmd = CMD_MARK_FREE;
      else cmd = cmd_t'(2'd3);
      r = $urandom_range(0, 9);
      if (r == 0) cnt = $urandom & 17'h1ffff;
      else if (r == 1) cnt = 0;
      else if (r == 2) cnt = $urandom_range(1, 512);
      else cnt = $urandom_range(1, total / 4 + 2);
      if ($urandom_range(0, 9) == 0) page = $urandom & 16'hffff;
      else page = $urandom_range(0, (total + 4 > 65535) ? 65535 : total + 4);
      send(cmd, cnt, $urandom_range(0, 1), page);
      rand_count++;
    end
  endtask

  initial begin
    ledger = new();
    rand_count = 0;
    tx_idle = 23; rx_idle = 73;
    rst <= 1'b1;
    in_valid <= 1'b0; in_data <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (!in_ready);

    // directed: default sizes, buddy rounding, rejects, range clipping
    send(CMD_REQUEST, 1, 0, 0);
    send(CMD_REQUEST, 3, 0, 0);
    send(CMD_REQUEST, 5, 0, 0);
    send(CMD_REQUEST, 512, 0, 16'hffff);
    send(CMD_REQUEST, 513, 0, 0);
    send(CMD_REQUEST, 0, 1, 0);
    send(CMD_REQUEST, 10, 1, 0);
    send(CMD_MARK_USED, 17'h1ffff, 0, 16'hffff);
    send(cmd_t'(2'd3), 1, 1, 1);
    send(CMD_MARK_FREE, 65536, 1, 0);
    send(CMD_REQUEST, 65536, 1, 0);
    // total above the page limit acts as the limit
    set_memory(17'h1ffff, 0);
    send(CMD_REQUEST, 1, 0, 0);
    send(CMD_MARK_USED, 1, 0, 16'hffff);
    // empty memory: everything rejected, free count saturates
    set_memory(0, 0);
    send(CMD_REQUEST, 1, 0, 0);
    send(CMD_MARK_USED, 1, 0, 0);
    // contiguous start beyond memory
    set_memory(100, 16'hffff);
    send(CMD_REQUEST, 1, 1, 0);
    send(CMD_REQUEST, 4, 0, 0);
    send(CMD_MARK_FREE, 100, 0, 0);

    random_phase(64, 0, 180);
    random_phase(256, 17, 180);
    random_phase(37, 5, 180);
    random_phase(200, 150, 180);
    random_phase(1, 0, 170);
    random_phase(512, 0, 180);
    random_phase(128, 16'hffff, 180);

    drain();
    repeat (100) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0)
      $display("buddy_bitmap_page_allocator_core_test OK");
    else
      $display("buddy_bitmap_page_allocator_core_test NOT OK");
    $finish;
  end
endmodule
